/* src/mrd_pkg.sv */
// Package for the RTU response deframer: sizes, CRC constants, result codes,
// the result record and the byte-wise CRC-16 update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned PosW  = 9;
   localparam int unsigned CrcW  = 16;

   localparam logic [CrcW-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CrcW-1:0] CRC_POLY = 16'hA001;

   // Bit of the function code that marks an exception response.
   localparam int unsigned EXC_BIT = 7;

   // Address, function and count or exception code precede the payload.
   localparam logic [PosW-1:0] HDR_LEN = 9'd3;

   // Highest position the frame counter can reach (CRC high byte of the
   // longest frame).
   localparam logic [PosW-1:0] POS_MAX = 9'd259;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
   localparam logic [1:0] STATUS_EXCEPTION = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [ByteW-1:0] data_byte;
      logic [ByteW-1:0] payload_index;
      logic [1:0]       status;
      logic [ByteW-1:0] unit_address;
      logic [ByteW-1:0] function_code;
      logic [ByteW-1:0] exception_code;
      logic [ByteW-1:0] payload_length;
   } result_type;

   // One byte into the reflected CRC-16, least significant bit first.
   function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage : mrd_pkg

`default_nettype wire

/* src/mrd_in_stage.sv */
// Input register of the RTU response deframer: holds one received byte
// until the framing stage takes it. Depends on mrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrd_in_stage
   import mrd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [ByteW-1:0] req_rx_byte,
   output logic                  req_stall,
   input  wire logic             take,
   output logic                  in_valid,
   output logic [ByteW-1:0]      in_byte
);

   logic             valid_ff;
   logic             valid_in;
   logic [ByteW-1:0] byte_ff;

   // The register is free when empty or when its byte leaves this cycle.
   assign req_stall = valid_ff && !take;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule : mrd_in_stage

`default_nettype wire

/* src/mrd_framer.sv */
// Framing stage of the RTU response deframer: frame position, running CRC,
// held header bytes and the result decode for one byte. Depends on mrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrd_framer
   import mrd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [ByteW-1:0] in_byte,
   output logic                  res_valid,
   output result_type            res
);

   logic [PosW-1:0]  pos_ff,  pos_in;
   logic [CrcW-1:0]  crc_ff,  crc_in;
   logic [ByteW-1:0] addr_ff, addr_in;
   logic [ByteW-1:0] func_ff, func_in;
   logic [ByteW-1:0] cnt_ff,  cnt_in;
   logic [ByteW-1:0] crc_lo_ff, crc_lo_in;

   logic             exc;
   logic [PosW-1:0]  payload_end;
   logic [PosW-1:0]  pos_offset;
   logic [CrcW-1:0]  crc_next;
   logic [CrcW-1:0]  received;

   assign exc         = func_ff[EXC_BIT];
   assign payload_end = exc ? HDR_LEN : HDR_LEN + {1'b0, cnt_ff};
   assign pos_offset  = pos_ff - HDR_LEN;
   assign crc_next    = crc_feed(crc_ff, in_byte);
   assign received    = {in_byte, crc_lo_ff};

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      cnt_in    = cnt_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res       = '0;
      if (step) begin
         if (pos_ff < HDR_LEN) begin
            // Header bytes are captured and fed to the CRC.
            case (pos_ff[1:0])
               2'd0:    addr_in = in_byte;
               2'd1:    func_in = in_byte;
               default: cnt_in  = in_byte;
            endcase
            crc_in = crc_next;
            pos_in = pos_ff + 9'd1;
         end else if (pos_ff < payload_end) begin
            res_valid           = 1'b1;
            res.kind            = KIND_PAYLOAD;
            res.data_byte       = in_byte;
            res.payload_index   = pos_offset[ByteW-1:0];
            res.unit_address    = addr_ff;
            res.function_code   = func_ff;
            res.payload_length  = cnt_ff;
            crc_in              = crc_next;
            pos_in              = pos_ff + 9'd1;
         end else if (pos_ff == payload_end) begin
            crc_lo_in = in_byte;
            pos_in    = pos_ff + 9'd1;
         end else begin
            // CRC high byte closes the frame; a bad CRC outranks exception.
            res_valid          = 1'b1;
            res.kind           = KIND_STATUS;
            res.unit_address   = addr_ff;
            res.function_code  = func_ff;
            res.exception_code = exc ? cnt_ff : 8'h00;
            res.payload_length = exc ? 8'h00 : cnt_ff;
            if (received != crc_ff) begin
               res.status = STATUS_CRC_ERR;
            end else if (exc) begin
               res.status = STATUS_EXCEPTION;
            end else begin
               res.status = STATUS_OK;
            end
            pos_in = '0;
            crc_in = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      func_ff   <= func_in;
      cnt_ff    <= cnt_in;
      crc_lo_ff <= crc_lo_in;
   end

`ifndef NO_ASSERTIONS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("frame position beyond the longest frame");

   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      (step && pos_ff < HDR_LEN) |-> !res_valid)
      else $error("result produced on a header byte");

   a_status_restarts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_STATUS) |=> (pos_ff == '0 && crc_ff == CRC_INIT))
      else $error("frame state not restarted after status");

   a_exc_no_payload: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_PAYLOAD) |-> !exc)
      else $error("payload byte reported for an exception frame");
`endif

endmodule : mrd_framer

`default_nettype wire

/* src/mrd_out_stage.sv */
// Result register of the RTU response deframer: holds one result beat
// until the receiver takes it. Depends on mrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrd_out_stage
   import mrd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_valid,
   input  wire result_type res,
   output logic            ready,
   input  wire logic       rsp_stall,
   output logic            rsp_valid,
   output result_type      rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // Free when empty or when the held beat is taken this cycle.
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = ready ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule : mrd_out_stage

`default_nettype wire

/* src/modbus_rtu_response_deframer.sv */
// Top level of the RTU response deframer: input register, framing stage and
// result register. Depends on mrd_pkg, mrd_in_stage, mrd_framer, mrd_out_stage.
//
// Usage: received serial bytes enter one per beat on the req_ channel
// (req_valid, req_rx_byte, req_stall). Each frame starts with the unit
// address and function code; an exception frame is five bytes, a normal one
// five plus its byte count. Every payload byte leaves as a kind 0 beat on the
// rsp_ channel; the CRC high byte, last of the frame, leaves as a kind 1 beat
// carrying ok, CRC mismatch or exception status. Header and CRC low bytes
// produce no beat.
// Path: an accepted byte passes the input register, the combinational framing
// stage and the result register before its beat shows on the rsp_ ports.
// Throughput: one byte per cycle while rsp_stall is low; the CRC update for a
// whole byte is a short XOR network in the framing stage, no loop over cycles.
// Reset (synchronous, active high) empties both registers, returns the frame
// position to the address byte and sets the CRC to all ones.
// When the receiver raises rsp_stall, the held result beat stays put; the
// framing stage then halts and req_stall rises once the input register holds
// a byte, so no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_deframer
   import mrd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [ByteW-1:0] req_rx_byte,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_kind,
   output logic [ByteW-1:0]      rsp_data_byte,
   output logic [ByteW-1:0]      rsp_payload_index,
   output logic [1:0]            rsp_status,
   output logic [ByteW-1:0]      rsp_unit_address,
   output logic [ByteW-1:0]      rsp_function_code,
   output logic [ByteW-1:0]      rsp_exception_code,
   output logic [ByteW-1:0]      rsp_payload_length
);

   logic             in_valid;
   logic [ByteW-1:0] in_byte;
   logic             out_ready;
   logic             step;
   logic             res_valid;
   result_type       res;
   result_type       rsp;

   // A byte is processed exactly when the result register can take its beat.
   assign step = in_valid && out_ready;

   mrd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .take        (out_ready),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   mrd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   mrd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .ready     (out_ready),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind           = rsp.kind;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_payload_index  = rsp.payload_index;
   assign rsp_status         = rsp.status;
   assign rsp_unit_address   = rsp.unit_address;
   assign rsp_function_code  = rsp.function_code;
   assign rsp_exception_code = rsp.exception_code;
   assign rsp_payload_length = rsp.payload_length;

endmodule : modbus_rtu_response_deframer

`default_nettype wire
